>>> sv/gas_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gas_pkg
// Shared types, constants and helpers of the grid path search block.
// ----------------------------------------------------------------------------
package gas_pkg;

    localparam int MAX_ROWS = 64;
    localparam int MAX_COLS = 64;
    localparam int ROW_W    = 6;
    localparam int COL_W    = 6;
    localparam int ID_W     = ROW_W + COL_W;
    localparam int CELLS    = MAX_ROWS * MAX_COLS;
    localparam int CNT_W    = ID_W + 1;
    localparam int COST_W   = 16;
    localparam int KEY_W    = COST_W + 1;
    localparam int EST_W    = 7;
    localparam int CFG_W    = 7;
    localparam int IDX_W    = 12;

    localparam logic [3:0] STEP_STRAIGHT = 4'd10;
    localparam logic [3:0] STEP_DIAG     = 4'd14;

    localparam logic [1:0] REQ_LOAD   = 2'd0;
    localparam logic [1:0] REQ_SEARCH = 2'd1;
    localparam logic [1:0] REQ_READ   = 2'd2;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_FOUND   = 2'd1;
    localparam logic [1:0] ST_NO_PATH = 2'd2;
    localparam logic [1:0] ST_SAME    = 2'd3;

    localparam logic CFG_ROWS = 1'b0;
    localparam logic CFG_COLS = 1'b1;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [ID_W-1:0]  id;
    } heap_ent_t;

    typedef enum logic [27:0] {
        OP_MAPCLR = 28'h0000001,
        OP_IDLE   = 28'h0000002,
        OP_LOAD   = 28'h0000004,
        OP_CLR    = 28'h0000008,
        OP_CHK    = 28'h0000010,
        OP_INIT   = 28'h0000020,
        OP_POP0   = 28'h0000040,
        OP_POP1   = 28'h0000080,
        OP_POP2   = 28'h0000100,
        OP_SD0    = 28'h0000200,
        OP_SD1    = 28'h0000400,
        OP_SD2    = 28'h0000800,
        OP_SD3    = 28'h0001000,
        OP_SU0    = 28'h0002000,
        OP_SU1    = 28'h0004000,
        OP_FIXW   = 28'h0008000,
        OP_CLOSE  = 28'h0010000,
        OP_NB0    = 28'h0020000,
        OP_NB1    = 28'h0040000,
        OP_NB2    = 28'h0080000,
        OP_NEXT   = 28'h0100000,
        OP_TR0    = 28'h0200000,
        OP_TR1    = 28'h0400000,
        OP_TW0    = 28'h0800000,
        OP_TW1    = 28'h1000000,
        OP_RD0    = 28'h2000000,
        OP_RD1    = 28'h4000000,
        OP_RESP   = 28'h8000000
    } op_t;

    typedef struct packed {
        logic       in_valid;
        logic [1:0] in_type;
        logic       clr_last;
        logic       grid_ok;
        logic       start_is_goal;
        logic       heap_empty;
        logic       kid_in;
        logic       kid1_in;
        logic       x_le_ch;
        logic       moved;
        logic       at_root;
        logic       x_ge_par;
        logic       fix_from_pop;
        logic       nb_ok;
        logic       nb_skip;
        logic       nb_open;
        logic       nb_better;
        logic       nb_last;
        logic       at_goal;
        logic       tr_end;
        logic       tw_last;
        logic       out_free;
    } dp_sts_t;

    // Manhattan distance from a cell to the goal
    function automatic logic [EST_W-1:0] est_of(logic [ID_W-1:0] id,
                                                logic [ROW_W-1:0] gr,
                                                logic [COL_W-1:0] gc);
        logic [ROW_W-1:0] r;
        logic [COL_W-1:0] c;
        logic [ROW_W-1:0] dr;
        logic [COL_W-1:0] dc;
        r  = id[ID_W-1:COL_W];
        c  = id[COL_W-1:0];
        dr = (r > gr) ? r - gr : gr - r;
        dc = (c > gc) ? c - gc : gc - c;
        return EST_W'({1'b0, dr}) + EST_W'({1'b0, dc});
    endfunction

endpackage

>>> sv/gas_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gas_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module gas_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/gas_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gas_ctrl
// Sequencer of the path search: map clear, load, search, trace and read.
// ----------------------------------------------------------------------------
module gas_ctrl import gas_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  dp_sts_t sts,
    output op_t     op,
    output logic    s_ready
);

    op_t op_reg;
    op_t op_next;

    always_comb begin
        op_next = op_reg;
        unique case (op_reg)
            OP_MAPCLR: if (sts.clr_last) op_next = OP_IDLE;
            OP_IDLE: begin
                if (sts.in_valid) begin
                    case (sts.in_type)
                        REQ_LOAD:   op_next = OP_LOAD;
                        REQ_SEARCH: op_next = OP_CLR;
                        REQ_READ:   op_next = OP_RD0;
                        default:    op_next = OP_RESP;
                    endcase
                end
            end
            OP_LOAD:  op_next = OP_RESP;
            OP_CLR:   if (sts.clr_last) op_next = OP_CHK;
            OP_CHK:   op_next = sts.grid_ok ? OP_INIT : OP_RESP;
            OP_INIT:  op_next = sts.start_is_goal ? OP_RESP : OP_POP0;
            OP_POP0:  op_next = OP_POP1;
            OP_POP1:  op_next = OP_POP2;
            OP_POP2:  op_next = sts.heap_empty ? OP_CLOSE : OP_SD0;
            OP_SD0: begin
                if (sts.kid_in) op_next = OP_SD1;
                else            op_next = sts.moved ? OP_FIXW : OP_SU0;
            end
            OP_SD1:   op_next = sts.kid1_in ? OP_SD2 : OP_SD3;
            OP_SD2:   op_next = OP_SD3;
            OP_SD3: begin
                if (sts.x_le_ch) op_next = sts.moved ? OP_FIXW : OP_SU0;
                else             op_next = OP_SD0;
            end
            OP_SU0:   op_next = sts.at_root ? OP_FIXW : OP_SU1;
            OP_SU1:   op_next = sts.x_ge_par ? OP_FIXW : OP_SU0;
            OP_FIXW:  op_next = sts.fix_from_pop ? OP_CLOSE : OP_NEXT;
            OP_CLOSE: op_next = sts.at_goal ? OP_TR0 : OP_NB0;
            OP_NB0:   op_next = sts.nb_ok ? OP_NB1 : OP_NEXT;
            OP_NB1:   op_next = (!sts.nb_skip && sts.nb_open) ? OP_NB2 : OP_NEXT;
            OP_NB2:   op_next = sts.nb_better ? OP_SD0 : OP_NEXT;
            OP_NEXT: begin
                if (sts.nb_last) op_next = sts.heap_empty ? OP_RESP : OP_POP0;
                else             op_next = OP_NB0;
            end
            OP_TR0:   op_next = sts.tr_end ? OP_TW0 : OP_TR1;
            OP_TR1:   op_next = OP_TR0;
            OP_TW0:   op_next = sts.tw_last ? OP_RESP : OP_TW1;
            OP_TW1:   op_next = OP_TW0;
            OP_RD0:   op_next = OP_RD1;
            OP_RD1:   op_next = OP_RESP;
            OP_RESP:  if (sts.out_free) op_next = OP_IDLE;
            default:  op_next = OP_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_reg <= OP_MAPCLR;
        end else begin
            op_reg <= op_next;
        end
    end

    assign op      = op_reg;
    assign s_ready = (op_reg == OP_IDLE);

endmodule

>>> sv/gas_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gas_dp
// Datapath: grid map, open heap with position table, flags, parents, path.
// ----------------------------------------------------------------------------
module gas_dp import gas_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  op_t                 op,
    output dp_sts_t             sts,
    input  logic                s_valid,
    input  logic [1:0]          s_req_type,
    input  logic [ROW_W-1:0]    s_cell_row,
    input  logic [COL_W-1:0]    s_cell_col,
    input  logic                s_cell_open,
    input  logic [ROW_W-1:0]    s_start_row,
    input  logic [COL_W-1:0]    s_start_col,
    input  logic [ROW_W-1:0]    s_goal_row,
    input  logic [COL_W-1:0]    s_goal_col,
    input  logic [IDX_W-1:0]    s_path_index,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [1:0]          m_status,
    output logic [CNT_W-1:0]    m_path_length,
    output logic [ROW_W-1:0]    m_path_row,
    output logic [COL_W-1:0]    m_path_col,
    input  logic                cfg_wr_en,
    input  logic                cfg_addr,
    input  logic [CFG_W-1:0]    cfg_wr_data
);

    logic [CFG_W-1:0] row_count_reg, col_count_reg;
    logic [ROW_W-1:0] cell_row_reg, start_row_reg, goal_row_reg;
    logic [COL_W-1:0] cell_col_reg, start_col_reg, goal_col_reg;
    logic             cell_open_reg;
    logic [IDX_W-1:0] path_idx_reg;

    logic [CNT_W-1:0] size_reg, stored_len_reg;
    logic [ID_W-1:0]  clr_cnt_reg;
    logic [ID_W-1:0]  cur_id_reg;
    logic [COST_W-1:0] cur_cost_reg;
    heap_ent_t        x_reg, ch_reg;
    logic [ID_W-1:0]  ch_pos_reg, hpos_reg, pos_reg;
    logic             moved_reg, fix_pop_reg;
    logic [2:0]       k_reg;
    logic [ID_W-1:0]  nb_id_reg;
    logic [3:0]       nb_w_reg;
    logic [EST_W-1:0] nb_est_reg;
    logic [ID_W-1:0]  tr_cur_reg;
    logic [CNT_W-1:0] tr_n_reg, tr_k_reg;
    logic [1:0]       resp_status_reg;
    logic [ROW_W-1:0] resp_row_reg;
    logic [COL_W-1:0] resp_col_reg;
    logic             m_valid_reg;
    logic [1:0]       m_status_reg;
    logic [CNT_W-1:0] m_len_reg;
    logic [ROW_W-1:0] m_row_reg;
    logic [COL_W-1:0] m_col_reg;

    // memory ports
    logic                    pass_we, pass_wdata, pass_rd;
    logic [ID_W-1:0]         pass_waddr;
    logic                    flag_we;
    logic [1:0]              flag_wdata, flag_rd;
    logic [ID_W-1:0]         flag_waddr;
    logic                    pos_we;
    logic [ID_W-1:0]         pos_waddr, pos_wdata, pos_rd;
    logic                    heap_we;
    logic [ID_W-1:0]         heap_waddr, heap_raddr;
    heap_ent_t               heap_wdata;
    logic [$bits(heap_ent_t)-1:0] heap_rd;
    logic                    par_we;
    logic [ID_W-1:0]         par_waddr, par_rd;
    logic                    path_we;
    logic [ID_W-1:0]         path_waddr;

    logic [CFG_W-1:0] eff_rows, eff_cols;
    logic [ID_W-1:0]  start_id, goal_id;
    heap_ent_t        heap_q;
    logic [CNT_W:0]   kid, kid1;
    logic [ID_W-1:0]  up_pos;
    logic [ROW_W-1:0] cr, nr;
    logic [COL_W-1:0] cc, nc;
    logic             dn, upw, rt, lf, nb_ok_c;
    logic [3:0]       nb_w_c;
    logic [ID_W-1:0]  nb_id_c;
    logic [KEY_W-1:0] ng, new_key;
    logic [COST_W-1:0] nb_cost;
    logic             nb_skip, heap_full, nb_ins, nb_better, accept, out_free;

    assign accept   = (op == OP_IDLE) && s_valid;
    assign out_free = !m_valid_reg || m_ready;
    assign eff_rows = (row_count_reg > CFG_W'(MAX_ROWS)) ? CFG_W'(MAX_ROWS) : row_count_reg;
    assign eff_cols = (col_count_reg > CFG_W'(MAX_COLS)) ? CFG_W'(MAX_COLS) : col_count_reg;
    assign start_id = {start_row_reg, start_col_reg};
    assign goal_id  = {goal_row_reg, goal_col_reg};
    assign heap_q   = heap_ent_t'(heap_rd);
    assign kid      = {1'b0, hpos_reg, 1'b1};
    assign kid1     = kid + (CNT_W+1)'(1);
    assign up_pos   = (hpos_reg - ID_W'(1)) >> 1;

    // neighbour of the expanded cell, fixed visiting order
    assign cr  = cur_id_reg[ID_W-1:COL_W];
    assign cc  = cur_id_reg[COL_W-1:0];
    assign dn  = ({1'b0, cr} + CFG_W'(1)) < eff_rows;
    assign upw = (cr != '0);
    assign rt  = ({1'b0, cc} + CFG_W'(1)) < eff_cols;
    assign lf  = (cc != '0);

    always_comb begin
        nr = cr;
        nc = cc;
        nb_ok_c = 1'b0;
        nb_w_c = STEP_DIAG;
        case (k_reg)
            3'd0: begin nr = cr + 1'b1; nb_ok_c = dn; nb_w_c = STEP_STRAIGHT; end
            3'd1: begin nr = cr - 1'b1; nb_ok_c = upw; nb_w_c = STEP_STRAIGHT; end
            3'd2: begin nc = cc + 1'b1; nb_ok_c = rt; nb_w_c = STEP_STRAIGHT; end
            3'd3: begin nc = cc - 1'b1; nb_ok_c = lf; nb_w_c = STEP_STRAIGHT; end
            3'd4: begin nr = cr + 1'b1; nc = cc + 1'b1; nb_ok_c = dn && rt; end
            3'd5: begin nr = cr + 1'b1; nc = cc - 1'b1; nb_ok_c = dn && lf; end
            3'd6: begin nr = cr - 1'b1; nc = cc + 1'b1; nb_ok_c = upw && rt; end
            default: begin nr = cr - 1'b1; nc = cc - 1'b1; nb_ok_c = upw && lf; end
        endcase
    end
    assign nb_id_c = {nr, nc};

    assign ng        = KEY_W'(cur_cost_reg) + KEY_W'(nb_w_reg);
    assign new_key   = KEY_W'(ng[COST_W-1:0]) + KEY_W'(nb_est_reg);
    assign nb_cost   = COST_W'(heap_q.key - KEY_W'(nb_est_reg));
    assign nb_better = KEY_W'(nb_cost) > ng;
    assign nb_skip   = !pass_rd || flag_rd[1];
    assign heap_full = (size_reg == CNT_W'(CELLS));
    assign nb_ins    = !nb_skip && !flag_rd[0] && !heap_full;

    // memory write and read steering
    always_comb begin
        pass_we = 1'b0;  pass_waddr = clr_cnt_reg;  pass_wdata = 1'b0;
        flag_we = 1'b0;  flag_waddr = clr_cnt_reg;  flag_wdata = 2'b00;
        pos_we  = 1'b0;  pos_waddr  = nb_id_reg;    pos_wdata  = hpos_reg;
        heap_we = 1'b0;  heap_waddr = hpos_reg;     heap_wdata = x_reg;
        par_we  = 1'b0;  par_waddr  = nb_id_reg;
        path_we = 1'b0;  path_waddr = ID_W'(tr_k_reg - CNT_W'(1));
        heap_raddr = '0;
        case (op)
            OP_MAPCLR: pass_we = 1'b1;
            OP_LOAD: begin
                pass_we    = ({3'b0, cell_row_reg} < 9'(MAX_ROWS))
                          && ({3'b0, cell_col_reg} < 9'(MAX_COLS));
                pass_waddr = {cell_row_reg, cell_col_reg};
                pass_wdata = cell_open_reg;
            end
            OP_CLR: flag_we = 1'b1;
            OP_INIT: begin
                flag_we    = 1'b1;  flag_waddr = start_id;  flag_wdata = 2'b01;
                pos_we     = 1'b1;  pos_waddr  = start_id;  pos_wdata  = '0;
                heap_we    = 1'b1;  heap_waddr = '0;
                heap_wdata = '{key: KEY_W'(est_of(start_id, goal_row_reg, goal_col_reg)),
                               id: start_id};
            end
            OP_POP1: heap_raddr = ID_W'(size_reg - CNT_W'(1));
            OP_SD0:  heap_raddr = kid[ID_W-1:0];
            OP_SD1:  heap_raddr = kid1[ID_W-1:0];
            OP_SD3: begin
                heap_we    = !sts.x_le_ch;  heap_wdata = ch_reg;
                pos_we     = !sts.x_le_ch;  pos_waddr  = ch_reg.id;
            end
            OP_SU0:  heap_raddr = up_pos;
            OP_SU1: begin
                heap_we    = !sts.x_ge_par; heap_wdata = heap_q;
                pos_we     = !sts.x_ge_par; pos_waddr  = heap_q.id;
            end
            OP_FIXW: begin
                heap_we = 1'b1;
                pos_we  = 1'b1;  pos_waddr = x_reg.id;
            end
            OP_CLOSE: begin
                flag_we = 1'b1;  flag_waddr = cur_id_reg;  flag_wdata = 2'b11;
            end
            OP_NB1: begin
                heap_raddr = pos_rd;
                flag_we    = nb_ins;  flag_waddr = nb_id_reg;  flag_wdata = 2'b01;
                pos_we     = nb_ins;  pos_wdata  = size_reg[ID_W-1:0];
                heap_we    = nb_ins;  heap_waddr = size_reg[ID_W-1:0];
                heap_wdata = '{key: new_key, id: nb_id_reg};
                par_we     = nb_ins;
            end
            OP_NB2: par_we = nb_better;
            OP_TW0: path_we = 1'b1;
            default: ;
        endcase
    end

    gas_ram #(.WIDTH(1), .DEPTH(CELLS)) u_pass (
        .aclk(aclk), .we(pass_we), .waddr(pass_waddr), .wdata(pass_wdata),
        .raddr(nb_id_c), .rdata(pass_rd)
    );

    gas_ram #(.WIDTH(2), .DEPTH(CELLS)) u_flag (
        .aclk(aclk), .we(flag_we), .waddr(flag_waddr), .wdata(flag_wdata),
        .raddr(nb_id_c), .rdata(flag_rd)
    );

    gas_ram #(.WIDTH(ID_W), .DEPTH(CELLS)) u_pos (
        .aclk(aclk), .we(pos_we), .waddr(pos_waddr), .wdata(pos_wdata),
        .raddr(nb_id_c), .rdata(pos_rd)
    );

    gas_ram #(.WIDTH($bits(heap_ent_t)), .DEPTH(CELLS)) u_heap (
        .aclk(aclk), .we(heap_we), .waddr(heap_waddr), .wdata(heap_wdata),
        .raddr(heap_raddr), .rdata(heap_rd)
    );

    gas_ram #(.WIDTH(ID_W), .DEPTH(CELLS)) u_parent (
        .aclk(aclk), .we(par_we), .waddr(par_waddr), .wdata(cur_id_reg),
        .raddr(tr_cur_reg), .rdata(par_rd)
    );

    logic [ID_W-1:0] path_rd;

    gas_ram #(.WIDTH(ID_W), .DEPTH(CELLS)) u_path (
        .aclk(aclk), .we(path_we), .waddr(path_waddr), .wdata(tr_cur_reg),
        .raddr(path_idx_reg), .rdata(path_rd)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_count_reg  <= CFG_W'(MAX_ROWS);
            col_count_reg  <= CFG_W'(MAX_COLS);
            size_reg       <= '0;
            stored_len_reg <= '0;
            clr_cnt_reg    <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    CFG_ROWS: row_count_reg <= cfg_wr_data;
                    CFG_COLS: col_count_reg <= cfg_wr_data;
                endcase
            end

            case (op)
                OP_MAPCLR: clr_cnt_reg <= clr_cnt_reg + 1'b1;
                OP_IDLE: begin
                    if (accept) begin
                        cell_row_reg  <= s_cell_row;
                        cell_col_reg  <= s_cell_col;
                        cell_open_reg <= s_cell_open;
                        start_row_reg <= s_start_row;
                        start_col_reg <= s_start_col;
                        goal_row_reg  <= s_goal_row;
                        goal_col_reg  <= s_goal_col;
                        path_idx_reg  <= s_path_index;
                        resp_status_reg <= ST_DONE;
                        resp_row_reg  <= '0;
                        resp_col_reg  <= '0;
                    end
                end
                OP_CLR: begin
                    clr_cnt_reg    <= clr_cnt_reg + 1'b1;
                    size_reg       <= '0;
                    stored_len_reg <= '0;
                end
                OP_CHK: if (!sts.grid_ok) resp_status_reg <= ST_NO_PATH;
                OP_INIT: begin
                    size_reg <= CNT_W'(1);
                    if (sts.start_is_goal) resp_status_reg <= ST_SAME;
                end
                OP_POP1: begin
                    cur_id_reg   <= heap_q.id;
                    cur_cost_reg <= COST_W'(heap_q.key
                                  - KEY_W'(est_of(heap_q.id, goal_row_reg, goal_col_reg)));
                    size_reg     <= size_reg - 1'b1;
                end
                OP_POP2: begin
                    x_reg       <= heap_q;
                    hpos_reg    <= '0;
                    moved_reg   <= 1'b0;
                    fix_pop_reg <= 1'b1;
                end
                OP_SD1: begin
                    ch_reg     <= heap_q;
                    ch_pos_reg <= kid[ID_W-1:0];
                end
                OP_SD2: begin
                    if (ch_reg.key > heap_q.key) begin
                        ch_reg     <= heap_q;
                        ch_pos_reg <= kid1[ID_W-1:0];
                    end
                end
                OP_SD3: begin
                    if (!sts.x_le_ch) begin
                        hpos_reg  <= ch_pos_reg;
                        moved_reg <= 1'b1;
                    end
                end
                OP_SU1: if (!sts.x_ge_par) hpos_reg <= up_pos;
                OP_CLOSE: begin
                    k_reg      <= '0;
                    tr_cur_reg <= cur_id_reg;
                    tr_n_reg   <= '0;
                end
                OP_NB0: begin
                    nb_id_reg  <= nb_id_c;
                    nb_w_reg   <= nb_w_c;
                    nb_est_reg <= est_of(nb_id_c, goal_row_reg, goal_col_reg);
                end
                OP_NB1: begin
                    pos_reg <= pos_rd;
                    if (nb_ins) size_reg <= size_reg + 1'b1;
                end
                OP_NB2: begin
                    if (nb_better) begin
                        x_reg       <= '{key: new_key, id: nb_id_reg};
                        hpos_reg    <= pos_reg;
                        moved_reg   <= 1'b0;
                        fix_pop_reg <= 1'b0;
                    end
                end
                OP_NEXT: begin
                    k_reg <= k_reg + 1'b1;
                    if (sts.nb_last && sts.heap_empty) resp_status_reg <= ST_NO_PATH;
                end
                OP_TR0: begin
                    tr_n_reg <= tr_n_reg + 1'b1;
                    if (sts.tr_end) begin
                        tr_k_reg   <= tr_n_reg + 1'b1;
                        tr_cur_reg <= goal_id;
                    end
                end
                OP_TR1: tr_cur_reg <= par_rd;
                OP_TW0: begin
                    tr_k_reg <= tr_k_reg - 1'b1;
                    if (sts.tw_last) begin
                        stored_len_reg  <= tr_n_reg;
                        resp_status_reg <= ST_FOUND;
                    end
                end
                OP_TW1: tr_cur_reg <= par_rd;
                OP_RD1: begin
                    if ({1'b0, path_idx_reg} < stored_len_reg) begin
                        resp_row_reg <= path_rd[ID_W-1:COL_W];
                        resp_col_reg <= path_rd[COL_W-1:0];
                    end
                end
                default: ;
            endcase

            if (op == OP_RESP && out_free) begin
                m_valid_reg  <= 1'b1;
                m_status_reg <= resp_status_reg;
                m_len_reg    <= stored_len_reg;
                m_row_reg    <= resp_row_reg;
                m_col_reg    <= resp_col_reg;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_comb begin
        sts.in_valid      = s_valid;
        sts.in_type       = s_req_type;
        sts.clr_last      = (clr_cnt_reg == ID_W'(CELLS - 1));
        sts.grid_ok       = ({1'b0, start_row_reg} < eff_rows) && ({1'b0, goal_row_reg} < eff_rows)
                         && ({1'b0, start_col_reg} < eff_cols) && ({1'b0, goal_col_reg} < eff_cols);
        sts.start_is_goal = (start_id == goal_id);
        sts.heap_empty    = (size_reg == '0);
        sts.kid_in        = kid < {1'b0, size_reg};
        sts.kid1_in       = kid1 < {1'b0, size_reg};
        sts.x_le_ch       = x_reg.key <= ch_reg.key;
        sts.moved         = moved_reg;
        sts.at_root       = (hpos_reg == '0);
        sts.x_ge_par      = x_reg.key >= heap_q.key;
        sts.fix_from_pop  = fix_pop_reg;
        sts.nb_ok         = nb_ok_c;
        sts.nb_skip       = nb_skip;
        sts.nb_open       = flag_rd[0];
        sts.nb_better     = nb_better;
        sts.nb_last       = (k_reg == 3'd7);
        sts.at_goal       = (cur_id_reg == goal_id);
        sts.tr_end        = (tr_cur_reg == start_id) || ((tr_n_reg + 1'b1) >= CNT_W'(CELLS));
        sts.tw_last       = (tr_k_reg == CNT_W'(1));
        sts.out_free      = out_free;
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_path_length = m_len_reg;
    assign m_path_row    = m_row_reg;
    assign m_path_col    = m_col_reg;

endmodule

>>> sv/grid_a_star_path_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_a_star_path_search
// A* search on a 64 x 64 grid, 8-way moves, binary-heap open list.
// ----------------------------------------------------------------------------
// One transaction at a time. After reset the map is cleared to barriers, and
// no transaction is taken meanwhile. A search first clears its flag RAM, then
// for each expanded cell pops the heap and visits each neighbour, with a sift
// for each decrease-key, and finally traces the path back through the parents
// and stores it; every step makes at most one read and one write per simple
// dual-port RAM. The result register frees the input once it is loaded.
module grid_a_star_path_search import gas_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_req_type,
    input  logic [ROW_W-1:0]    s_cell_row,
    input  logic [COL_W-1:0]    s_cell_col,
    input  logic                s_cell_open,
    input  logic [ROW_W-1:0]    s_start_row,
    input  logic [COL_W-1:0]    s_start_col,
    input  logic [ROW_W-1:0]    s_goal_row,
    input  logic [COL_W-1:0]    s_goal_col,
    input  logic [IDX_W-1:0]    s_path_index,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [1:0]          m_status,
    output logic [CNT_W-1:0]    m_path_length,
    output logic [ROW_W-1:0]    m_path_row,
    output logic [COL_W-1:0]    m_path_col,
    input  logic                cfg_wr_en,
    input  logic                cfg_addr,
    input  logic [CFG_W-1:0]    cfg_wr_data
);

    op_t     op;
    dp_sts_t sts;

    gas_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .sts     (sts),
        .op      (op),
        .s_ready (s_ready)
    );

    gas_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .op            (op),
        .sts           (sts),
        .s_valid       (s_valid),
        .s_req_type    (s_req_type),
        .s_cell_row    (s_cell_row),
        .s_cell_col    (s_cell_col),
        .s_cell_open   (s_cell_open),
        .s_start_row   (s_start_row),
        .s_start_col   (s_start_col),
        .s_goal_row    (s_goal_row),
        .s_goal_col    (s_goal_col),
        .s_path_index  (s_path_index),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_path_length (m_path_length),
        .m_path_row    (m_path_row),
        .m_path_col    (m_path_col),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wr_data   (cfg_wr_data)
    );

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Grid path search block: loads maps, runs searches and reads back paths,
// predicting every response with a behavioral A* model and comparing each
// response transaction field by field under random sender gaps and stalls.
// ----------------------------------------------------------------------------
module tb_top;
    import gas_pkg::*;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic [1:0]          s_req_type;
    logic [ROW_W-1:0]    s_cell_row;
    logic [COL_W-1:0]    s_cell_col;
    logic                s_cell_open;
    logic [ROW_W-1:0]    s_start_row;
    logic [COL_W-1:0]    s_start_col;
    logic [ROW_W-1:0]    s_goal_row;
    logic [COL_W-1:0]    s_goal_col;
    logic [IDX_W-1:0]    s_path_index;
    logic                m_valid;
    logic                m_ready;
    logic [1:0]          m_status;
    logic [CNT_W-1:0]    m_path_length;
    logic [ROW_W-1:0]    m_path_row;
    logic [COL_W-1:0]    m_path_col;
    logic                cfg_wr_en;
    logic                cfg_addr;
    logic [CFG_W-1:0]    cfg_wr_data;

    grid_a_star_path_search DUT (.*);

    typedef struct packed {
        logic [1:0]       status;
        logic [CNT_W-1:0] length;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } resp_t;

    // Predictor state
    bit              walk_map [CELLS];
    int unsigned     g_cost   [CELLS];
    int unsigned     h_est    [CELLS];
    bit              open_f   [CELLS];
    bit              closed_f [CELLS];
    int unsigned     par      [CELLS];
    bit              par_ok   [CELLS];
    int unsigned     heap     [CELLS];
    int unsigned     heap_n;
    int unsigned     path_cells [CELLS];
    int unsigned     path_len;
    int unsigned     rows_cfg, cols_cfg;
    int unsigned     last_len;   // length of last found path, for reads

    resp_t           expected_q [$];
    int              errors = 0;
    int              idle_cycles = 0;
    int              burst_left;

    initial begin
        aclk = 0;
        forever #1 aclk = ~aclk;
    end

    function automatic int unsigned rows_eff();
        return rows_cfg < MAX_ROWS ? rows_cfg : MAX_ROWS;
    endfunction

    function automatic int unsigned cols_eff();
        return cols_cfg < MAX_COLS ? cols_cfg : MAX_COLS;
    endfunction

    function automatic int unsigned key_of(int unsigned pos);
        return g_cost[heap[pos]] + h_est[heap[pos]];
    endfunction

    function automatic void heap_swap(int unsigned a, int unsigned b);
        int unsigned t;
        t = heap[a];
        heap[a] = heap[b];
        heap[b] = t;
    endfunction

    function automatic void heap_restore(int unsigned n);
        int unsigned cur, kid, up;
        if (n >= heap_n) return;
        cur = n;
        kid = 2 * cur + 1;
        while (kid < heap_n) begin
            if (kid + 1 < heap_n && key_of(kid) > key_of(kid + 1)) kid++;
            if (key_of(cur) <= key_of(kid)) break;
            heap_swap(kid, cur);
            cur = kid;
            kid = 2 * cur + 1;
        end
        if (cur != n) return;
        while (cur != 0) begin
            up = (cur - 1) / 2;
            if (key_of(cur) >= key_of(up)) break;
            heap_swap(cur, up);
            cur = up;
        end
    endfunction

    function automatic int unsigned abs_diff(int unsigned a, int unsigned b);
        return a > b ? a - b : b - a;
    endfunction

    function automatic void relax_cell(int unsigned r, int unsigned c, int unsigned from,
                                       int unsigned gr, int unsigned gc, int unsigned w);
        int unsigned id, ng, i;
        id = r * MAX_COLS + c;
        ng = g_cost[from] + w;
        if (!walk_map[id] || closed_f[id]) return;
        if (open_f[id]) begin
            if (g_cost[id] > ng) begin
                g_cost[id] = ng & 16'hFFFF;
                par[id] = from;
                par_ok[id] = 1;
                for (i = 0; i < heap_n; i++)
                    if (heap[i] == id) break;
                heap_restore(i);
            end
        end else begin
            if (heap_n >= CELLS) return;
            g_cost[id] = ng & 16'hFFFF;
            h_est[id] = (abs_diff(gr, r) + abs_diff(gc, c)) & 8'hFF;
            par[id] = from;
            par_ok[id] = 1;
            open_f[id] = 1;
            heap[heap_n++] = id;
        end
    endfunction

    function automatic void expand_cell(int unsigned id, int unsigned gr, int unsigned gc);
        int unsigned r, c;
        bit dn, up, rt, lf;
        r = id / MAX_COLS;
        c = id % MAX_COLS;
        dn = r + 1 < rows_eff();
        up = r >= 1;
        rt = c + 1 < cols_eff();
        lf = c >= 1;
        if (dn) relax_cell(r + 1, c, id, gr, gc, STEP_STRAIGHT);
        if (up) relax_cell(r - 1, c, id, gr, gc, STEP_STRAIGHT);
        if (rt) relax_cell(r, c + 1, id, gr, gc, STEP_STRAIGHT);
        if (lf) relax_cell(r, c - 1, id, gr, gc, STEP_STRAIGHT);
        if (dn && rt) relax_cell(r + 1, c + 1, id, gr, gc, STEP_DIAG);
        if (dn && lf) relax_cell(r + 1, c - 1, id, gr, gc, STEP_DIAG);
        if (up && rt) relax_cell(r - 1, c + 1, id, gr, gc, STEP_DIAG);
        if (up && lf) relax_cell(r - 1, c - 1, id, gr, gc, STEP_DIAG);
    endfunction

    function automatic logic [1:0] search_path(int unsigned sr, int unsigned sc,
                                               int unsigned gr, int unsigned gc);
        int unsigned st, goal, cur, n, k;
        for (int i = 0; i < CELLS; i++) begin
            g_cost[i] = 0; h_est[i] = 0; open_f[i] = 0;
            closed_f[i] = 0; par[i] = 0; par_ok[i] = 0;
        end
        heap_n = 0;
        path_len = 0;
        if (sr >= rows_eff() || gr >= rows_eff() || sc >= cols_eff() || gc >= cols_eff())
            return ST_NO_PATH;
        st = sr * MAX_COLS + sc;
        goal = gr * MAX_COLS + gc;
        heap[heap_n++] = st;
        open_f[st] = 1;
        h_est[st] = abs_diff(gr, sr) + abs_diff(gc, sc);
        if (st == goal) return ST_SAME;
        forever begin
            cur = heap[0];
            heap_n--;
            heap[0] = heap[heap_n];
            heap_restore(0);
            closed_f[cur] = 1;
            if (cur == goal) break;
            expand_cell(cur, gr, gc);
            if (heap_n == 0) return ST_NO_PATH;
        end
        n = 0;
        cur = goal;
        forever begin
            n++;
            if (!par_ok[cur] || n >= CELLS) break;
            cur = par[cur];
        end
        cur = goal;
        for (k = n; k > 0; k--) begin
            path_cells[k - 1] = cur;
            cur = par[cur];
        end
        path_len = n;
        return ST_FOUND;
    endfunction

    function automatic resp_t predict_resp(logic [1:0] kind, logic [5:0] cr, logic [5:0] cc,
                                           logic op, logic [5:0] sr, logic [5:0] sc,
                                           logic [5:0] gr, logic [5:0] gc,
                                           logic [IDX_W-1:0] idx);
        resp_t e;
        e = '0;
        if (kind == REQ_LOAD) walk_map[cr * MAX_COLS + cc] = op;
        else if (kind == REQ_SEARCH) e.status = search_path(sr, sc, gr, gc);
        else if (kind == REQ_READ && idx < path_len) begin
            e.row = ROW_W'(path_cells[idx] / MAX_COLS);
            e.col = COL_W'(path_cells[idx] % MAX_COLS);
        end
        e.length = CNT_W'(path_len);
        last_len = path_len;
        return e;
    endfunction

    // Sends one transaction, holding valid until accepted; bursty gaps.
    task automatic send_req(int unsigned kind, int unsigned cr, int unsigned cc,
                            int unsigned op, int unsigned sr, int unsigned sc,
                            int unsigned gr, int unsigned gc, int unsigned idx);
        logic [1:0]       kind_f;
        logic [ROW_W-1:0] cr_f, sr_f, gr_f;
        logic [COL_W-1:0] cc_f, sc_f, gc_f;
        logic             op_f;
        logic [IDX_W-1:0] idx_f;
        resp_t            exp_r;
        kind_f = 2'(kind);
        cr_f   = ROW_W'(cr);
        cc_f   = COL_W'(cc);
        op_f   = op[0];
        sr_f   = ROW_W'(sr);
        sc_f   = COL_W'(sc);
        gr_f   = ROW_W'(gr);
        gc_f   = COL_W'(gc);
        idx_f  = IDX_W'(idx);
        if (burst_left == 0) begin
            repeat ($urandom_range(0, 4)) @(posedge aclk);
            burst_left = $urandom_range(1, 8);
        end
        burst_left--;
        s_valid      <= 1;
        s_req_type   <= kind_f;
        s_cell_row   <= cr_f;
        s_cell_col   <= cc_f;
        s_cell_open  <= op_f;
        s_start_row  <= sr_f;
        s_start_col  <= sc_f;
        s_goal_row   <= gr_f;
        s_goal_col   <= gc_f;
        s_path_index <= idx_f;
        exp_r = predict_resp(kind_f, cr_f, cc_f, op_f, sr_f, sc_f, gr_f, gc_f, idx_f);
        expected_q.insert(expected_q.size(), exp_r);
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        s_valid <= 0;
        @(posedge aclk);
    endtask

    task automatic load_cell(int r, int c, bit op);
        send_req(REQ_LOAD, r, c, op, $urandom, $urandom, $urandom, $urandom, $urandom);
    endtask

    task automatic run_search(int sr, int sc, int gr, int gc);
        send_req(REQ_SEARCH, $urandom, $urandom, $urandom, sr, sc, gr, gc, $urandom);
    endtask

    task automatic read_path(int idx);
        send_req(REQ_READ, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, idx);
    endtask

    task automatic drain();
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_cfg(logic addr, int unsigned val);
        cfg_wr_en   <= 1;
        cfg_addr    <= addr;
        cfg_wr_data <= CFG_W'(val);
        if (addr == CFG_ROWS) rows_cfg = val & 7'h7F;
        else cols_cfg = val & 7'h7F;
        @(posedge aclk);
        cfg_wr_en <= 0;
        @(posedge aclk);
    endtask

    task automatic set_grid(int unsigned r, int unsigned c);
        drain();
        write_cfg(CFG_ROWS, r);
        write_cfg(CFG_COLS, c);
    endtask

    // Small open region with a wall; searches and path readback.
    task automatic test_directed();
        set_grid(6, 6);
        for (int r = 0; r < 6; r++)
            for (int c = 0; c < 6; c++)
                load_cell(r, c, !(c == 2 && r < 4));
        load_cell(63, 63, 1);
        run_search(0, 0, 0, 5);
        for (int i = 0; i < 8; i++) read_path(i);
        read_path(4095);
        run_search(3, 3, 3, 3);
        run_search(0, 0, 6, 0);
        load_cell(5, 5, 0);
        run_search(0, 0, 5, 5);
        load_cell(0, 0, 0);
        run_search(0, 0, 1, 1);
        read_path(1);
        send_req(2'd3, 0, 0, 1, 0, 0, 0, 0, 0);
    endtask

    // 127 (saturating) setting, then zero-sized, single-cell and full 64 x 64 grids.
    task automatic test_config_extremes();
        set_grid(127, 127);
        load_cell(62, 62, 1);
        load_cell(62, 63, 1);
        run_search(62, 62, 63, 63);
        run_search(62, 62, 62, 63);
        read_path(1);
        set_grid(0, 64);
        run_search(0, 0, 0, 1);
        set_grid(1, 1);
        run_search(0, 0, 0, 0);
        set_grid(64, 64);
        load_cell(0, 0, 1);
        load_cell(1, 1, 1);
        run_search(0, 0, 1, 1);
        read_path(0);
    endtask

    // Random mazes on small grids: loads, searches, reads and random requests; then the full grid.
    task automatic test_random_mazes();
        int unsigned rn, cn;
        for (int m = 0; m < 4; m++) begin
            rn = $urandom_range(2, 5);
            cn = $urandom_range(2, 5);
            set_grid(rn, cn);
            for (int k = 0; k < 9; k++) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: load_cell($urandom_range(0, rn), $urandom_range(0, cn),
                                             $urandom_range(0, 3) != 0);
                    5, 6: run_search($urandom_range(0, rn), $urandom_range(0, cn),
                                     $urandom_range(0, rn), $urandom_range(0, cn));
                    7, 8: read_path($urandom_range(0, last_len + 1));
                    default: send_req($urandom_range(0, 3), $urandom, $urandom, $urandom,
                                      $urandom, $urandom, $urandom, $urandom, $urandom);
                endcase
            end
        end
        set_grid(64, 64);
        send_req(REQ_LOAD, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom);
        run_search($urandom, $urandom, $urandom, $urandom);
        read_path($urandom);
    endtask

    // Response checker with its own stall pattern.
    always @(posedge aclk) begin
        resp_t e;
        if (!aresetn) begin
            m_ready <= 0;
        end else begin
            m_ready <= ($urandom_range(0, 15) < 11) || (idle_cycles % 64 > 40);
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected response transaction", $realtime);
                    errors++;
                end else begin
                    e = expected_q.pop_front();
                    if (m_status !== e.status) begin
                        $display("%0t: status exp %0d got %0d", $realtime, e.status, m_status);
                        errors++;
                    end
                    if (m_path_length !== e.length) begin
                        $display("%0t: path_length exp %0d got %0d", $realtime,
                                 e.length, m_path_length);
                        errors++;
                    end
                    if (m_path_row !== e.row) begin
                        $display("%0t: path_row exp %0d got %0d", $realtime, e.row, m_path_row);
                        errors++;
                    end
                    if (m_path_col !== e.col) begin
                        $display("%0t: path_col exp %0d got %0d", $realtime, e.col, m_path_col);
                        errors++;
                    end
                end
            end
        end
    end

    // Watchdog: cycles with no accepted transaction; covers map clear and searches.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 400000) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        burst_left = 0;
        path_len = 0;
        last_len = 0;
        rows_cfg = 64;
        cols_cfg = 64;
        for (int i = 0; i < CELLS; i++) walk_map[i] = 0;
        aresetn      = 0;
        s_valid      = 0;
        s_req_type   = 0;
        s_cell_row   = 0;
        s_cell_col   = 0;
        s_cell_open  = 0;
        s_start_row  = 0;
        s_start_col  = 0;
        s_goal_row   = 0;
        s_goal_col   = 0;
        s_path_index = 0;
        cfg_wr_en    = 0;
        cfg_addr     = 0;
        cfg_wr_data  = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        test_directed();
        test_config_extremes();
        test_random_mazes();
        drain();
        if (errors == 0 && expected_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

>>> files.f
sv/gas_pkg.sv
sv/gas_ram.sv
sv/gas_ctrl.sv
sv/gas_dp.sv
sv/grid_a_star_path_search.sv
verif/tb_top.sv
